// File: rtl/lsw_pkg.sv
// shared types and constants for the lap stopwatch core
package lsw_pkg;

   localparam int LAP_DEPTH_DEF = 8;

   // request codes, codes six and seven behave as a query
   localparam logic [2:0] REQ_TICK  = 3'd1;
   localparam logic [2:0] REQ_START = 3'd2;
   localparam logic [2:0] REQ_STOP  = 3'd3;
   localparam logic [2:0] REQ_LAP   = 3'd4;
   localparam logic [2:0] REQ_RESET = 3'd5;

   // exact divide by 100 of a 32-bit value: (x * DIV100_MUL) >> DIV100_SHIFT
   localparam logic [31:0] DIV100_MUL   = 32'd1374389535;
   localparam int          DIV100_SHIFT = 37;
   localparam int          QUOT_W       = 26;
   // exact divide by 15 of a 24-bit value: (x * DIV15_MUL) >> DIV15_SHIFT
   localparam logic [31:0] DIV15_MUL    = 32'h8888_8889;
   localparam int          DIV15_SHIFT  = 35;
   localparam int          MIN_W        = 21;
   localparam logic [6:0]  MINUTES_CAP  = 7'd99;

   typedef struct packed {
      logic [2:0] req_type;
      logic [2:0] lap_index;
      logic       format_lap;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  run_status;
      logic [31:0] elapsed_total;
      logic [3:0]  laps_held;
      logic [31:0] lap_at_index;
      logic        lap_present;
      logic        display_event;
      logic [6:0]  shown_minutes;
      logic [5:0]  shown_seconds;
      logic [6:0]  shown_centis;
   } rsp_payload_type;

   // snapshot handed from the request stage to the formatter
   typedef struct packed {
      logic [1:0]  run_status;
      logic [31:0] elapsed_total;
      logic [3:0]  laps_held;
      logic [31:0] lap_at_index;
      logic        lap_present;
      logic        display_event;
      logic [31:0] value;
   } fmt_in_type;

endpackage

// File: rtl/lsw_format.sv
// three-stage min/sec/centi breakdown pipeline with output register
module lsw_format (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  lsw_pkg::fmt_in_type      in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output lsw_pkg::rsp_payload_type out_data
);
   import lsw_pkg::*;

   logic                 a_vld_ff;
   fmt_in_type           a_data_ff;
   logic [63:0]          a_prod_ff;

   logic                 b_vld_ff;
   fmt_in_type           b_data_ff;
   logic [QUOT_W-1:0]    b_quot_ff;
   logic [6:0]           b_centi_ff;
   logic [55:0]          b_prod_ff;

   logic                 out_vld_ff;
   rsp_payload_type      out_data_ff;

   logic                 en_a, en_b, en_out;
   logic [QUOT_W-1:0]    quot100;
   logic [31:0]          back100;
   logic [MIN_W-1:0]     quot6000;
   logic [QUOT_W-1:0]    back60;

   // a stage loads when empty or when the stage after it moves
   assign en_out   = !out_vld_ff || !out_stall;
   assign en_b     = !b_vld_ff || en_out;
   assign en_a     = !a_vld_ff || en_b;
   assign in_stall = !en_a;

   assign quot100  = a_prod_ff[DIV100_SHIFT +: QUOT_W];
   assign back100  = 32'(quot100) * 32'd100;
   assign quot6000 = b_prod_ff[DIV15_SHIFT +: MIN_W];
   assign back60   = QUOT_W'(quot6000) * QUOT_W'(60);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_vld_ff <= in_valid;
         end
         if (en_b) begin
            b_vld_ff <= a_vld_ff;
         end
         if (en_out) begin
            out_vld_ff <= b_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_data_ff <= in_data;
         a_prod_ff <= 64'(in_data.value) * 64'(DIV100_MUL);
      end
      if (en_b) begin
         b_data_ff  <= a_data_ff;
         b_quot_ff  <= quot100;
         b_centi_ff <= a_data_ff.value[6:0] - back100[6:0];
         // value / 6000 = (value / 100 / 4) / 15
         b_prod_ff  <= 56'(quot100[QUOT_W-1:2]) * 56'(DIV15_MUL);
      end
      if (en_out) begin
         out_data_ff.run_status    <= b_data_ff.run_status;
         out_data_ff.elapsed_total <= b_data_ff.elapsed_total;
         out_data_ff.laps_held     <= b_data_ff.laps_held;
         out_data_ff.lap_at_index  <= b_data_ff.lap_at_index;
         out_data_ff.lap_present   <= b_data_ff.lap_present;
         out_data_ff.display_event <= b_data_ff.display_event;
         out_data_ff.shown_minutes <= (quot6000 > MIN_W'(MINUTES_CAP)) ?
                                      MINUTES_CAP : quot6000[6:0];
         out_data_ff.shown_seconds <= b_quot_ff[5:0] - back60[5:0];
         out_data_ff.shown_centis  <= b_centi_ff;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

endmodule

// File: rtl/lap_stopwatch_core.sv
// centisecond stopwatch with newest-first lap store, top level
//
//   port group    direction  flow control       carries
//   req_*         in         req_valid/stall    req_type, lap_index, format_lap
//   rsp_*         out        rsp_valid/stall    status, totals, lap and breakdown
//
// one request per cycle sustained while rsp_stall stays low; each result passes the stages
// (request register, divide-by-100 multiply, divide-by-60 multiply, output register)
// the watch state updates in the cycle of the request transfer itself
// synchronous reset clears mode, count and lap count; lap entries are not cleared
// a stalled rsp holds the output register; stages behind it fill their bubbles and
// req_stall rises only once all four stages hold a result
module lap_stopwatch_core #(
   parameter int LAP_DEPTH = lsw_pkg::LAP_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lsw_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lsw_pkg::rsp_payload_type rsp_payload
);
   import lsw_pkg::*;

   localparam int CNT_W = $clog2(LAP_DEPTH + 1);
   localparam int CMP_W = CNT_W + 3;
   localparam int VIEW_N = 8;

   typedef enum logic [1:0] {
      IDLE    = 2'd0,
      RUNNING = 2'd1,
      PAUSED  = 2'd2
   } mode_type;

   // watch state
   mode_type          mode_ff, mode_in;
   logic [31:0]       count_ff, count_in;
   logic [3:0]        digit_ff, digit_in;     // count mod 10
   logic [CNT_W-1:0]  laps_ff, laps_in;
   logic [31:0]       last_ff, last_in;       // count at the previous lap
   logic [31:0]       store_ff [LAP_DEPTH];
   logic [31:0]       store_in [LAP_DEPTH];
   logic              store_push;

   // request register feeding the formatter
   logic              s1_vld_ff;
   fmt_in_type        s1_ff, s1_in;
   logic              fmt_stall;

   logic              accept;
   logic              tick_event;
   logic [31:0]       lap_view [VIEW_N];
   logic [31:0]       lap_val;
   logic              present;

   assign req_stall = s1_vld_ff && fmt_stall;
   assign accept    = req_valid && !req_stall;

   // next watch state for the request on the port
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      digit_in   = digit_ff;
      laps_in    = laps_ff;
      last_in    = last_ff;
      tick_event = 1'b0;
      store_push = 1'b0;
      case (req_payload.req_type)
         REQ_TICK: begin
            if (mode_ff == RUNNING) begin
               count_in = count_ff + 32'd1;
               // wrap to zero lands on a multiple of ten as well
               if (count_ff == '1 || digit_ff == 4'd9) begin
                  digit_in   = 4'd0;
                  tick_event = 1'b1;
               end else begin
                  digit_in = digit_ff + 4'd1;
               end
            end
         end
         REQ_START: begin
            mode_in = RUNNING;
         end
         REQ_STOP: begin
            if (mode_ff == RUNNING) begin
               mode_in = PAUSED;
            end
         end
         REQ_LAP: begin
            if (mode_ff == RUNNING && laps_ff < CNT_W'(LAP_DEPTH)) begin
               store_push = 1'b1;
               last_in    = count_ff;
               laps_in    = laps_ff + CNT_W'(1);
            end
         end
         REQ_RESET: begin
            if (mode_ff != RUNNING) begin
               mode_in  = IDLE;
               count_in = '0;
               digit_in = '0;
               laps_in  = '0;
               last_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // lap push shifts the whole line; entries above the lap count are never shown
   always_comb begin
      for (int k = 0; k < LAP_DEPTH; k++) begin
         store_in[k] = store_ff[k];
      end
      if (store_push) begin
         store_in[0] = count_ff - last_ff;
         for (int k = 1; k < LAP_DEPTH; k++) begin
            store_in[k] = store_ff[k-1];
         end
      end
   end

   // lap_index reaches only the first eight entries
   for (genvar j = 0; j < VIEW_N; j++) begin : g_view
      if (j < LAP_DEPTH) begin : g_real
         assign lap_view[j] = store_in[j];
      end else begin : g_none
         assign lap_view[j] = '0;
      end
   end

   assign present = CMP_W'(req_payload.lap_index) < CMP_W'(laps_in);
   assign lap_val = present ? lap_view[req_payload.lap_index] : '0;

   always_comb begin
      s1_in.run_status    = mode_in;
      s1_in.elapsed_total = count_in;
      s1_in.laps_held     = 4'(laps_in);
      s1_in.lap_at_index  = lap_val;
      s1_in.lap_present   = present;
      s1_in.display_event = tick_event;
      s1_in.value         = req_payload.format_lap ? lap_val : count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= IDLE;
         count_ff  <= '0;
         digit_ff  <= '0;
         laps_ff   <= '0;
         last_ff   <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            digit_ff <= digit_in;
            laps_ff  <= laps_in;
            last_ff  <= last_in;
         end
         if (!s1_vld_ff || !fmt_stall) begin
            s1_vld_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
         for (int k = 0; k < LAP_DEPTH; k++) begin
            store_ff[k] <= store_in[k];
         end
      end
   end

   lsw_format u_format (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_stall  (fmt_stall),
      .in_data   (s1_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

   // a counted tick advances the count by exactly one
   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.req_type == REQ_TICK && mode_ff == RUNNING
      |=> count_ff == $past(count_ff) + 32'd1)
      else $error("counted tick did not advance the count");

   // a reset request while running leaves the watch running
   a_reset_ignored: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.req_type == REQ_RESET && mode_ff == RUNNING
      |=> mode_ff == RUNNING && count_ff == $past(count_ff))
      else $error("reset request acted while running");

   // the decade digit is zero whenever the count is zero
   a_digit_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> digit_ff == 4'd0)
      else $error("decade digit out of step with count");

   // lap count never passes the store depth
   a_lap_bound: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.req_type == REQ_LAP |=> laps_ff <= CNT_W'(LAP_DEPTH))
      else $error("lap count beyond store depth");

endmodule
